// ===== hw/rtl/bblur_pkg.sv =====
`timescale 1ns / 1ps

package bblur_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and storage widths
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int SIZE_W   = 11;
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int SUM_W    = 12;            // nine 8-bit values
  localparam int NUM_W    = SUM_W + 1;     // 2*sum + count
  localparam int CNT_W    = 4;             // up to nine neighbours
  localparam int DVS_W    = CNT_W + 1;     // 2*count
  localparam int QBIT_W   = $clog2(CH_W);
  localparam int CFG_IDX_W = 1;
  localparam int POS_S_W  = 13;            // signed frame coordinates

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Item sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE
  } blur_state_t;

  // Request to the divider
  typedef struct packed {
    logic                          start;
    logic                          last;
    logic [CNT_W-1:0]              count;
    logic [NUM_CH-1:0][NUM_W-1:0]  num;
  } div_req_t;

  // Divider status and result
  typedef struct packed {
    logic                          busy;
    logic                          valid;
    logic                          last;
    logic [NUM_CH-1:0][CH_W-1:0]   mean;
  } div_rsp_t;

  // Size register write value: zero acts as one, large values saturate
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid tready tdata[23:0]       pixel or filler
// m_axis    out  tvalid tready tdata[23:0] tlast blurred pixel
// cfg       in   cfg_we cfg_index cfg_data       frame_width (0), frame_height (1)
//
// An item that yields no pixel passes accept, line-store read and window update;
// one that yields a pixel also passes the bit-serial divider and the result load.
// The line-store memory ports and the divider set this sequence of steps.
// Reset clears positions, window and handshake state; size registers go to 1024.
// A result waiting on m_axis does not stop the next item being accepted; only
// a second result stalls, in the divide state, until the output register frees.
module box_blur_3x3_rgb (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [bblur_pkg::PIX_W-1:0]                s_axis_tdata,  // red_in, green_in, blue_in
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  output logic [bblur_pkg::PIX_W-1:0]                m_axis_tdata,  // red_out, green_out, blue_out
  output logic                                       m_axis_tlast,  // last_in_frame
  input  logic                                       cfg_we,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [bblur_pkg::SIZE_W-1:0]               cfg_data
);

  import bblur_pkg::*;

  blur_state_t       state;
  blur_state_t       state_next;

  logic [SIZE_W-1:0] frame_w;
  logic [SIZE_W-1:0] frame_h;
  logic [ADDR_W-1:0] col_pos;
  logic [ROW_W-1:0]  row_pos;

  logic [PIX_W-1:0]  item_px;
  logic [ADDR_W-1:0] item_col;
  logic [ROW_W-1:0]  item_row;
  logic              item_emit;
  logic              item_last;

  logic [PIX_W-1:0]  window [9];
  logic [PIX_W-1:0]  window_next [9];
  logic [PIX_W-1:0]  top_rd;
  logic [PIX_W-1:0]  mid_rd;

  logic              accept;
  logic              ram_re;
  logic              ram_we;
  logic              out_load;
  logic              slot_free;
  logic              at_row_end;
  logic              cur_emit;
  logic              cur_last;

  logic signed [POS_S_W-1:0] rbase;
  logic signed [POS_S_W-1:0] cbase;
  logic [2:0]                row_ok;
  logic [2:0]                col_ok;
  logic [NUM_CH-1:0][SUM_W-1:0] sums;
  logic [CNT_W-1:0]          count;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = item_emit ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (div_rsp.valid && slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_READ:   ram_re = 1'b1;
      ST_UPDATE: ram_we = 1'b1;
      ST_DIVIDE: out_load = div_rsp.valid && slot_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position flags of the incoming item
  assign at_row_end = ({1'b0, col_pos} + SIZE_W'(1)) >= frame_w;
  assign cur_emit   = (row_pos >= ROW_W'(2)) || (row_pos == ROW_W'(1) && col_pos != '0);
  assign cur_last   = (row_pos == ROW_W'(frame_h) + ROW_W'(1)) && col_pos == '0;

  // Size registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= SIZE_W'(MAX_WIDTH);
      frame_h <= SIZE_W'(MAX_HEIGHT);
      col_pos <= '0;
      row_pos <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_w <= clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: frame_h <= clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));
        default:          ;
      endcase
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (cur_last) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (at_row_end) begin
        col_pos <= '0;
        row_pos <= row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + ADDR_W'(1);
      end
    end
  end

  // Latch the accepted item; drain items store as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      item_px   <= (SIZE_W'(row_pos) < frame_h) ? s_axis_tdata : '0;
      item_col  <= col_pos;
      item_row  <= row_pos;
      item_emit <= cur_emit;
      item_last <= cur_last;
    end
  end

  // Line stores: upper holds two rows back, lower one row back
  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_col),
    .wdata (mid_rd),
    .re    (ram_re),
    .raddr (item_col),
    .rdata (top_rd)
  );

  bblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_col),
    .wdata (item_px),
    .re    (ram_re),
    .raddr (item_col),
    .rdata (mid_rd)
  );

  // Window shifts left by one column; new column from the stores and the item
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r*3 + 0] = window[r*3 + 1];
      window_next[r*3 + 1] = window[r*3 + 2];
    end
    window_next[2] = top_rd;
    window_next[5] = mid_rd;
    window_next[8] = item_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else if (ram_we) begin
      for (int i = 0; i < 9; i++) window[i] <= window_next[i];
    end
  end

  // Neighbour masks and sums. At column 0 the pixel is the last of an
  // earlier row, so the window before the shift is used.
  always_comb begin
    logic signed [POS_S_W-1:0] rr;
    logic signed [POS_S_W-1:0] cc;
    logic [PIX_W-1:0]          p;
    if (item_col == '0) begin
      rbase = signed'(POS_S_W'(item_row)) - POS_S_W'(3);
      cbase = signed'(POS_S_W'(frame_w)) - POS_S_W'(3);
    end else begin
      rbase = signed'(POS_S_W'(item_row)) - POS_S_W'(2);
      cbase = signed'(POS_S_W'(item_col)) - POS_S_W'(2);
    end
    for (int k = 0; k < 3; k++) begin
      rr = rbase + POS_S_W'(k);
      cc = cbase + POS_S_W'(k);
      row_ok[k] = (rr >= 0) && (rr < signed'(POS_S_W'(frame_h)));
      col_ok[k] = (cc >= 0) && (cc < signed'(POS_S_W'(frame_w)));
    end
    sums = '0;
    for (int i = 0; i < 9; i++) begin
      p = (item_col == '0) ? window[i] : window_next[i];
      if (row_ok[i / 3] && col_ok[i % 3]) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          sums[ch] = sums[ch] + SUM_W'(p[ch*CH_W +: CH_W]);
        end
      end
    end
    count = CNT_W'($countones(row_ok)) * CNT_W'($countones(col_ok));
  end

  // Rounded mean: (2*sum + count) / (2*count)
  always_comb begin
    div_req.start = ram_we && item_emit;
    div_req.last  = item_last;
    div_req.count = count;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      div_req.num[ch] = {sums[ch], 1'b0} + NUM_W'(count);
    end
  end

  bblur_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= div_rsp.mean;
      m_axis_tlast <= div_rsp.last;
    end
  end

  // Checks
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (count != '0))
    else $error("empty neighbourhood at divide start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (SIZE_W'(col_pos) < frame_w))
    else $error("column position beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    ((SIZE_W + 1)'(row_pos) <= (SIZE_W + 1)'(frame_h) + (SIZE_W + 1)'(1)))
    else $error("row position beyond drain rows");

endmodule

// ===== hw/rtl/bblur_ram.sv =====
`timescale 1ns / 1ps

module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bblur_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, three channels side by side, one quotient bit per cycle.
// Quotient fits in eight bits since the mean never exceeds 255.
module bblur_div (
  input  logic                clk,
  input  logic                rst,
  input  bblur_pkg::div_req_t req,
  output bblur_pkg::div_rsp_t rsp
);

  import bblur_pkg::*;

  logic [NUM_CH-1:0][NUM_W-1:0] rem;
  logic [NUM_CH-1:0][NUM_W-1:0] rem_next;
  logic [NUM_CH-1:0][CH_W-1:0]  quo;
  logic [NUM_CH-1:0][CH_W-1:0]  quo_next;
  logic [DVS_W-1:0]             dvs;
  logic [QBIT_W-1:0]            bit_idx;
  logic                         busy;
  logic                         valid;
  logic                         last;
  logic [NUM_W-1:0]             trial;

  // One trial subtraction per channel
  always_comb begin
    trial = NUM_W'(dvs) << bit_idx;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (rem[ch] >= trial) begin
        rem_next[ch] = rem[ch] - trial;
        quo_next[ch] = {quo[ch][CH_W-2:0], 1'b1};
      end else begin
        rem_next[ch] = rem[ch];
        quo_next[ch] = {quo[ch][CH_W-2:0], 1'b0};
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else if (req.start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
    end else if (busy && bit_idx == '0) begin
      busy  <= 1'b0;
      valid <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.num;
      quo     <= '0;
      dvs     <= {req.count, 1'b0};
      bit_idx <= QBIT_W'(CH_W - 1);
      last    <= req.last;
    end else if (busy) begin
      rem     <= rem_next;
      quo     <= quo_next;
      bit_idx <= bit_idx - QBIT_W'(1);
    end
  end

  assign rsp.busy  = busy;
  assign rsp.valid = valid;
  assign rsp.last  = last;
  assign rsp.mean  = quo;

endmodule
